[rtl/htdt_pkg.sv]
package htdt_pkg;

  // Register file: seven 64-bit terms, base in the upper word, yearly rate in the lower
  localparam int NUM_TERMS  = 7;
  localparam int REG_IDX_W  = 3;
  localparam int TERM_W     = 64;
  localparam int HALF_W     = 32;

  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCALE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROT_X   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Y   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Z   = 3'd6;

  // APB: 64-bit data, registers on 8-byte boundaries
  localparam int APB_DATA_W = 64;
  localparam int APB_BYTE_W = 3;
  localparam int APB_ADDR_W = APB_BYTE_W + REG_IDX_W;

  // Point epoch offset in whole years
  localparam int YEARS_W = 10;

  // base + rate * years always fits in 42 signed bits
  localparam int EFF_W = 42;

  // Unit conversion factors, Q96: 2^96 / 1e12 and 2^96 * pi / (180 * 3600 * 1e6)
  localparam int K_W       = 60;
  localparam int Q96_SHIFT = 96;
  localparam logic signed [K_W-1:0] SCALE_Q96 = 60'sd79228162514264338;
  localparam logic signed [K_W-1:0] UAS_Q96   = 60'sd384108971160850440;

  // Coefficient slots: the rotation slot index equals its axis
  localparam int NUM_AXES   = 3;
  localparam int COEF_ROT_X = 0;
  localparam int COEF_ROT_Y = 1;
  localparam int COEF_ROT_Z = 2;
  localparam int COEF_MULT  = 3;
  localparam int NUM_COEF   = 4;

  // Register stages inside the split multiplier
  localparam int MUL_LAT = 3;

endpackage

[rtl/htdt_pt_if.sv]
interface htdt_pt_if #(
  parameter int COORD_BITS = 48
);

  logic                                 valid;
  logic                                 ready;
  logic signed [COORD_BITS-1:0]         pos_x;
  logic signed [COORD_BITS-1:0]         pos_y;
  logic signed [COORD_BITS-1:0]         pos_z;
  logic signed [htdt_pkg::YEARS_W-1:0]  years_since_ref;

  modport source (
    output valid, pos_x, pos_y, pos_z, years_since_ref,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, years_since_ref,
    output ready
  );

endinterface

[rtl/htdt_res_if.sv]
interface htdt_res_if #(
  parameter int COORD_BITS = 48
);

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic                         overflow;

  modport source (
    output valid, out_x, out_y, out_z, overflow,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, overflow,
    output ready
  );

endinterface

[rtl/helmert_time_dependent_transform.sv]
// Time-dependent 14-parameter Helmert transform, one Earth-centred point per word.
// Input channel pt_i carries a point in micrometres and its epoch offset in years;
// output channel res_o carries the transformed point, rounded to nearest and
// saturated to COORD_BITS, with overflow set when any coordinate was clamped.
// The seven terms sit on the APB port, 8 bytes apart, and read back as written;
// write them only while no word is in flight.
// Throughput: one word per cycle while the skid register is empty. The chain registers,
// in order: the input word, year scaling, a 3-stage split multiplier for unit
// conversion, coefficient rounding, a second 3-stage split multiplier for the nine
// coordinate products, two adder stages, rounding and saturation, then the output
// register.
// Reset clears all terms to zero and empties the pipeline.
// When the receiver stalls, the next finished word drops into a skid register
// and the pipeline freezes until the output word is taken; pt_i.ready then
// falls. Nothing is lost or repeated.
module helmert_time_dependent_transform #(
  parameter int COORD_BITS      = 48,
  parameter int ANGLE_FRAC_BITS = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  htdt_pt_if.sink                             pt_i,
  htdt_res_if.source                          res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [htdt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [htdt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [htdt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CB    = COORD_BITS;
  localparam int F     = ANGLE_FRAC_BITS;
  localparam int EW    = htdt_pkg::EFF_W;
  localparam int KW    = htdt_pkg::K_W;
  localparam int CW    = F + 5;
  localparam int PW1   = EW + KW;
  localparam int SH1   = htdt_pkg::Q96_SHIFT - F;
  localparam int PW2   = CB + CW;
  localparam int ACC_W = PW2 + 3;
  localparam int RW    = ACC_W - F;
  localparam int NAX   = htdt_pkg::NUM_AXES;
  localparam int NCF   = htdt_pkg::NUM_COEF;
  localparam int NT    = htdt_pkg::NUM_TERMS;
  localparam int HW    = htdt_pkg::HALF_W;

  // Stage numbering
  localparam int ST_IN   = 0;
  localparam int ST_EFF  = 1;
  localparam int ST_COEF = ST_EFF + htdt_pkg::MUL_LAT + 1;
  localparam int ST_PROD = ST_COEF + htdt_pkg::MUL_LAT;
  localparam int ST_SUM  = ST_PROD + 1;
  localparam int ST_ACC  = ST_SUM + 1;
  localparam int ST_RND  = ST_ACC + 1;
  localparam int ST_SAT  = ST_RND + 1;

  localparam logic signed [PW1-1:0]   RND1    = PW1'(1) << (SH1 - 1);
  localparam logic signed [PW1-1:0]   ONE1    = PW1'(1) << htdt_pkg::Q96_SHIFT;
  localparam logic signed [ACC_W-1:0] RND2    = ACC_W'(1) << (F - 1);
  localparam logic [CB-1:0]           CRD_MIN = {1'b1, (CB - 1)'(0)};
  localparam logic [CB-1:0]           CRD_MAX = ~CRD_MIN;

  // Configuration
  logic [htdt_pkg::TERM_W-1:0]    cfg_q [NT];
  logic [htdt_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                           cfg_wr;

  // Pipeline control
  logic               pipe_en;
  logic [ST_SAT:0]    v_q;

  // Pipeline payload
  logic signed [CB-1:0]                 crd_q [ST_IN:ST_COEF][NAX];
  logic signed [htdt_pkg::YEARS_W-1:0]  yr_q;
  logic signed [EW-1:0]                 e1_d  [NT];
  logic signed [EW-1:0]                 e1_q  [NT];
  logic signed [EW-1:0]                 t_q   [ST_EFF+1:ST_PROD][NAX];
  logic signed [PW1-1:0]                p1    [NCF];
  logic signed [PW1-1:0]                sum1  [NCF];
  logic signed [CW-1:0]                 coef_d [NCF];
  logic signed [CW-1:0]                 coef_q [NCF];
  logic signed [PW2-1:0]                p2    [NAX][NAX];
  logic signed [ACC_W-1:0]              sa_d  [NAX];
  logic signed [ACC_W-1:0]              sb_d  [NAX];
  logic signed [ACC_W-1:0]              sa_q  [NAX];
  logic signed [ACC_W-1:0]              sb_q  [NAX];
  logic signed [ACC_W-1:0]              acc_q [NAX];
  logic signed [ACC_W-1:0]              rs_d  [NAX];
  logic signed [RW-1:0]                 r_q   [NAX];
  logic [CB-1:0]                        val_d [NAX];
  logic [CB-1:0]                        val_q [NAX];
  logic                                 ovf_d;
  logic                                 ovf_q;

  // Output register and skid register
  logic          out_v_q;
  logic          skid_v_q;
  logic [CB-1:0] out_q  [NAX];
  logic [CB-1:0] skid_q [NAX];
  logic          out_ovf_q;
  logic          skid_ovf_q;
  logic          out_fire;
  logic          mv_to_out;
  logic          mv_to_skid;
  logic          skid_to_out;

  // ---------------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------------
  assign cfg_idx = paddr[htdt_pkg::APB_ADDR_W-1:htdt_pkg::APB_BYTE_W];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Write a term; drop writes past the last register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NT; k++) begin
        cfg_q[k] <= '0;
      end
    end else if (cfg_wr && (cfg_idx <= htdt_pkg::REG_ROT_Z)) begin
      cfg_q[cfg_idx] <= pwdata;
    end
  end

  assign prdata = (cfg_idx <= htdt_pkg::REG_ROT_Z) ? cfg_q[cfg_idx] : '0;

  // ---------------------------------------------------------------------------
  // Flow control: the whole chain advances unless the skid register is full
  // ---------------------------------------------------------------------------
  assign pipe_en    = !skid_v_q;
  assign pt_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_en) begin
      v_q <= {v_q[ST_SAT-1:0], pt_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Effective terms: base + rate * years
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < NT; k++) begin
      e1_d[k] = EW'($signed(cfg_q[k][2*HW-1:HW]))
              + EW'($signed(cfg_q[k][HW-1:0])) * EW'(yr_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Unit conversion to Q.F radians and Q.F scale multiplier
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NCF; k++) begin : g_conv
    localparam int SRC = (k == htdt_pkg::COEF_MULT) ? int'(htdt_pkg::REG_SCALE)
                                                    : int'(htdt_pkg::REG_ROT_X) + k;
    localparam logic signed [KW-1:0] KCONST = (k == htdt_pkg::COEF_MULT) ?
                                              htdt_pkg::SCALE_Q96 : htdt_pkg::UAS_Q96;
    htdt_mul #(
      .AW (EW),
      .BW (KW)
    ) u_mul (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .a_i   (e1_q[SRC]),
      .b_i   (KCONST),
      .p_o   (p1[k])
    );
  end

  // Round to nearest; the scale slot also picks up the unit term 2^F here
  always_comb begin
    for (int k = 0; k < NCF; k++) begin
      sum1[k]   = p1[k] + RND1 + ((k == htdt_pkg::COEF_MULT) ? ONE1 : '0);
      coef_d[k] = sum1[k][SH1+CW-1:SH1];
    end
  end

  // ---------------------------------------------------------------------------
  // Nine coordinate products: row i, column j is coordinate j times its factor
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NAX; i++) begin : g_row
    for (genvar j = 0; j < NAX; j++) begin : g_col
      // Off the diagonal the rotation about the remaining axis applies
      localparam int CSEL = (i == j) ? htdt_pkg::COEF_MULT : (NAX - i - j);
      htdt_mul #(
        .AW (CB),
        .BW (CW)
      ) u_mul (
        .clk_i (clk_i),
        .en_i  (pipe_en),
        .a_i   (crd_q[ST_COEF][j]),
        .b_i   (coef_q[CSEL]),
        .p_o   (p2[i][j])
      );
    end

    // The next axis enters with a minus sign, the one after with a plus
    localparam int J_SUB = (i + 1) % NAX;
    localparam int J_ADD = (i + 2) % NAX;
    assign sa_d[i] = (ACC_W'(t_q[ST_PROD][i]) <<< F) + ACC_W'(p2[i][i]);
    assign sb_d[i] = ACC_W'(p2[i][J_ADD]) - ACC_W'(p2[i][J_SUB]);
    assign rs_d[i] = acc_q[i] + RND2;
  end

  // ---------------------------------------------------------------------------
  // Saturate to the coordinate range
  // ---------------------------------------------------------------------------
  always_comb begin
    ovf_d = 1'b0;
    for (int i = 0; i < NAX; i++) begin
      if ((&r_q[i][RW-1:CB-1]) || !(|r_q[i][RW-1:CB-1])) begin
        val_d[i] = r_q[i][CB-1:0];
      end else begin
        ovf_d    = 1'b1;
        val_d[i] = r_q[i][RW-1] ? CRD_MIN : CRD_MAX;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // Input stage
      crd_q[ST_IN][0] <= pt_i.pos_x;
      crd_q[ST_IN][1] <= pt_i.pos_y;
      crd_q[ST_IN][2] <= pt_i.pos_z;
      yr_q            <= pt_i.years_since_ref;

      // Carry coordinates to the product multipliers
      for (int s = ST_IN + 1; s <= ST_COEF; s++) begin
        for (int i = 0; i < NAX; i++) begin
          crd_q[s][i] <= crd_q[s-1][i];
        end
      end

      for (int k = 0; k < NT; k++) begin
        e1_q[k] <= e1_d[k];
      end

      // Carry translations to the first adder stage
      for (int i = 0; i < NAX; i++) begin
        t_q[ST_EFF+1][i] <= e1_q[int'(htdt_pkg::REG_SHIFT_X) + i];
      end
      for (int s = ST_EFF + 2; s <= ST_PROD; s++) begin
        for (int i = 0; i < NAX; i++) begin
          t_q[s][i] <= t_q[s-1][i];
        end
      end

      for (int k = 0; k < NCF; k++) begin
        coef_q[k] <= coef_d[k];
      end

      // Sum, round, saturate
      for (int i = 0; i < NAX; i++) begin
        sa_q[i]  <= sa_d[i];
        sb_q[i]  <= sb_d[i];
        acc_q[i] <= sa_q[i] + sb_q[i];
        r_q[i]   <= rs_d[i][ACC_W-1:F];
        val_q[i] <= val_d[i];
      end
      ovf_q <= ovf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid register
  // ---------------------------------------------------------------------------
  assign out_fire    = out_v_q && res_o.ready;
  assign mv_to_out   = !skid_v_q && v_q[ST_SAT] && (!out_v_q || out_fire);
  assign mv_to_skid  = !skid_v_q && v_q[ST_SAT] && out_v_q && !out_fire;
  assign skid_to_out = skid_v_q && out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_to_out || mv_to_out) begin
        out_v_q <= 1'b1;
      end else if (out_fire) begin
        out_v_q <= 1'b0;
      end
      if (mv_to_skid) begin
        skid_v_q <= 1'b1;
      end else if (skid_to_out) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  // Hold the output word until taken; park the next one in the skid register
  always_ff @(posedge clk_i) begin
    if (skid_to_out) begin
      for (int i = 0; i < NAX; i++) begin
        out_q[i] <= skid_q[i];
      end
      out_ovf_q <= skid_ovf_q;
    end else if (mv_to_out) begin
      for (int i = 0; i < NAX; i++) begin
        out_q[i] <= val_q[i];
      end
      out_ovf_q <= ovf_q;
    end
    if (mv_to_skid) begin
      for (int i = 0; i < NAX; i++) begin
        skid_q[i] <= val_q[i];
      end
      skid_ovf_q <= ovf_q;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.out_x    = out_q[0];
  assign res_o.out_y    = out_q[1];
  assign res_o.out_z    = out_q[2];
  assign res_o.overflow = out_ovf_q;

endmodule

[rtl/htdt_mul.sv]
// Signed AW x BW multiplier, split into four half-width partial products.
// Three register stages; everything advances together on en_i.
module htdt_mul #(
  parameter int AW = 48,
  parameter int BW = 45
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int LA = AW / 2;
  localparam int HA = AW - LA;
  localparam int LB = BW / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic        [LA-1:0]    a_lo;
  logic signed [HA-1:0]    a_hi;
  logic        [LB-1:0]    b_lo;
  logic signed [HB-1:0]    b_hi;

  logic        [LA+LB-1:0] ll_q;
  logic signed [LA+HB:0]   lh_q;
  logic signed [HA+LB:0]   hl_q;
  logic signed [HA+HB-1:0] hh_q;

  logic signed [PW-1:0]    cross_q;
  logic signed [PW-1:0]    hhll_q;
  logic signed [PW-1:0]    p_q;

  // Split operands: low halves unsigned, high halves carry the sign
  assign a_lo = a_i[LA-1:0];
  assign a_hi = a_i[AW-1:LA];
  assign b_lo = b_i[LB-1:0];
  assign b_hi = b_i[BW-1:LB];

  // Stage 1: partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_lo * b_lo;
      lh_q <= $signed({1'b0, a_lo}) * b_hi;
      hl_q <= a_hi * $signed({1'b0, b_lo});
      hh_q <= a_hi * b_hi;
    end
  end

  // Stage 2: the outer terms do not overlap, so they just concatenate;
  // each cross term sits at the weight of its high half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cross_q <= (PW'(lh_q) <<< LB) + (PW'(hl_q) <<< LA);
      hhll_q  <= {hh_q, ll_q};
    end
  end

  // Stage 3: final sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= hhll_q + cross_q;
    end
  end

  assign p_o = p_q;

endmodule
